// File: rtl/core/dvu64_pkg.sv
// shared types, constants and microcode rom for the 64 by 32 bit divider
// no dependencies; used by dvu64_datapath, divide_u64_by_u32_core and tb_top
package dvu64_pkg;

  localparam int DividendW = 64;
  localparam int DivisorW  = 32;
  localparam int CountW    = $clog2(DividendW);
  localparam int StepW     = 3;
  localparam int OpW       = 3;
  localparam int CondW     = 3;

  // datapath operations
  localparam logic [OpW-1:0] OP_NOP  = 3'd0;
  localparam logic [OpW-1:0] OP_LOAD = 3'd1;
  localparam logic [OpW-1:0] OP_ITER = 3'd2;
  localparam logic [OpW-1:0] OP_ZERO = 3'd3;
  localparam logic [OpW-1:0] OP_EMIT = 3'd4;

  // jump conditions
  localparam logic [CondW-1:0] COND_NEVER     = 3'd0;
  localparam logic [CondW-1:0] COND_NO_INPUT  = 3'd1;
  localparam logic [CondW-1:0] COND_DVSR_ZERO = 3'd2;
  localparam logic [CondW-1:0] COND_MORE_BITS = 3'd3;
  localparam logic [CondW-1:0] COND_OUT_BUSY  = 3'd4;
  localparam logic [CondW-1:0] COND_ALWAYS    = 3'd5;

  // program addresses
  localparam logic [StepW-1:0] STEP_WAIT  = 3'd0;
  localparam logic [StepW-1:0] STEP_CHECK = 3'd1;
  localparam logic [StepW-1:0] STEP_ITER  = 3'd2;
  localparam logic [StepW-1:0] STEP_ZERO  = 3'd3;
  localparam logic [StepW-1:0] STEP_EMIT  = 3'd4;

  typedef struct packed {
    logic             take;    // input port ready in this step
    logic [OpW-1:0]   op;
    logic [CondW-1:0] cond;
    logic [StepW-1:0] target;  // taken when cond holds
    logic [StepW-1:0] next;    // taken otherwise
  } uword_t;

  typedef struct packed {
    logic dvsr_zero;
    logic last_bit;
  } dp_status_t;

  function automatic uword_t ucode_rom(input logic [StepW-1:0] pc);
    uword_t w;
    w = '{take: 1'b0, op: OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT, next: STEP_WAIT};
    case (pc)
      STEP_WAIT:  w = '{take: 1'b1, op: OP_LOAD, cond: COND_NO_INPUT,
                        target: STEP_WAIT, next: STEP_CHECK};
      STEP_CHECK: w = '{take: 1'b0, op: OP_NOP, cond: COND_DVSR_ZERO,
                        target: STEP_ZERO, next: STEP_ITER};
      STEP_ITER:  w = '{take: 1'b0, op: OP_ITER, cond: COND_MORE_BITS,
                        target: STEP_ITER, next: STEP_EMIT};
      STEP_ZERO:  w = '{take: 1'b0, op: OP_ZERO, cond: COND_ALWAYS,
                        target: STEP_EMIT, next: STEP_EMIT};
      STEP_EMIT:  w = '{take: 1'b0, op: OP_EMIT, cond: COND_OUT_BUSY,
                        target: STEP_EMIT, next: STEP_WAIT};
      default:    w = '{take: 1'b0, op: OP_NOP, cond: COND_ALWAYS,
                        target: STEP_WAIT, next: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/dvu64_datapath.sv
// shift-and-subtract datapath of the divider, one quotient bit per iteration
// depends on dvu64_pkg for operation codes and the status struct
module dvu64_datapath import dvu64_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [OpW-1:0]       op,
  input  logic [DividendW-1:0] dividend,
  input  logic [DivisorW-1:0]  divisor,
  output dp_status_t           status,
  output logic [DividendW-1:0] quotient,
  output logic [DivisorW-1:0]  remainder,
  output logic                 divide_by_zero
);

  // work holds the dividend bits still to come in the top and quotient bits below
  logic [DividendW-1:0] work;
  logic [DivisorW-1:0]  dvsr;
  logic [DivisorW-1:0]  rem;
  logic                 dz;
  logic [CountW-1:0]    cnt;

  logic [DivisorW:0]    trial;
  logic [DivisorW+1:0]  diff;
  logic                 qbit;

  assign trial = {rem, work[DividendW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvsr};
  assign qbit  = ~diff[DivisorW+1];

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        work <= dividend;
        dvsr <= divisor;
        rem  <= '0;
        dz   <= (divisor == '0);
      end
      OP_ITER: begin
        work <= {work[DividendW-2:0], qbit};
        rem  <= qbit ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      end
      OP_ZERO: begin
        work <= '1;
        rem  <= '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (op == OP_LOAD) begin
      cnt <= '0;
    end else if (op == OP_ITER) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign status = '{dvsr_zero: dz, last_bit: (cnt == CountW'(DividendW - 1))};

  assign quotient       = work;
  assign remainder      = rem;
  assign divide_by_zero = dz;

endmodule

// File: rtl/core/divide_u64_by_u32_core.sv
// unsigned 64 by 32 bit restoring divider run by a five-step microcode program
// a new transaction is taken only in the wait step, once the previous result has gone into
// the output register; in between run the load, the divisor check, the 64 iterations of
// the single shift-and-subtract unit (a zero step instead for a zero divisor) and the result write
// reset: synchronous active-high rst returns the sequencer to the wait step and
// empties the output register; no clearing pass
module divide_u64_by_u32_core import dvu64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // [63:0] dividend, [95:64] divisor
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [63:0] quotient, [95:64] remainder
  output logic        m_tuser    // [0] divide_by_zero
);

  // sequencer
  logic [StepW-1:0] pc;
  logic [StepW-1:0] pc_next;
  uword_t           uword;
  logic             cond_true;
  logic [OpW-1:0]   dp_op;

  // datapath side
  dp_status_t           status;
  logic [DividendW-1:0] dp_quotient;
  logic [DivisorW-1:0]  dp_remainder;
  logic                 dp_dz;

  // output register
  logic out_busy;
  logic emit;

  assign uword    = ucode_rom(pc);
  assign out_busy = m_tvalid & ~m_tready;
  assign s_tready = uword.take;

  // condition select for the jump
  always_comb begin
    case (uword.cond)
      COND_NEVER:     cond_true = 1'b0;
      COND_NO_INPUT:  cond_true = ~s_tvalid;
      COND_DVSR_ZERO: cond_true = status.dvsr_zero;
      COND_MORE_BITS: cond_true = ~status.last_bit;
      COND_OUT_BUSY:  cond_true = out_busy;
      COND_ALWAYS:    cond_true = 1'b1;
      default:        cond_true = 1'b1;
    endcase
  end

  assign pc_next = cond_true ? uword.target : uword.next;

  // a load only happens with an actual transaction on the input side
  always_comb begin
    dp_op = uword.op;
    if (uword.op == OP_LOAD && !s_tvalid) begin
      dp_op = OP_NOP;
    end
  end

  assign emit = (uword.op == OP_EMIT) & ~out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  dvu64_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .op             (dp_op),
    .dividend       (s_tdata[DividendW-1:0]),
    .divisor        (s_tdata[DividendW+DivisorW-1:DividendW]),
    .status         (status),
    .quotient       (dp_quotient),
    .remainder      (dp_remainder),
    .divide_by_zero (dp_dz)
  );

  // output register keeps the result while the next transaction is taken in
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {dp_remainder, dp_quotient};
      m_tuser <= dp_dz;
    end
  end

`ifndef SYNTHESIS
  // an accepted transaction always moves on to the divisor check
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (pc == STEP_CHECK))
    else $error("sequencer did not move to divisor check after load");

  // the iteration step repeats until the last quotient bit
  a_iter_loops: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_ITER && !status.last_bit) |=> (pc == STEP_ITER))
    else $error("iteration left early");

  // a divide-by-zero result carries all-ones quotient and zero remainder
  a_dz_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[63:0] == '1 && m_tdata[95:64] == '0))
    else $error("divide-by-zero result has wrong payload");
`endif

endmodule

// File: tb/tb_top.sv
// self-checking testbench for divide_u64_by_u32_core, the 64 by 32 bit unsigned divider
// depends on dvu64_pkg and divide_u64_by_u32_core; expected results come from an
// in-bench restoring-division predictor or are typed into the directed rows, checked in order against the result stream
`timescale 1ns / 1ps

module tb_top;
  import dvu64_pkg::*;

  localparam int unsigned CycleLimit   = 1_500_000;
  localparam int unsigned RandomPerMix = 650;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned TailCycles   = 100;

  typedef struct packed {
    logic [DividendW-1:0] quot;
    logic [DivisorW-1:0]  rem;
    logic                 by_zero;
  } div_result_t;

  typedef struct {
    logic [DividendW-1:0] num;
    logic [DivisorW-1:0]  den;
    bit                   typed;  // expected result written into the row itself
    div_result_t          want;
  } div_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;  // [63:0] dividend, [95:64] divisor
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;       // [63:0] quotient, [95:64] remainder
  logic        m_tuser;       // [0] divide_by_zero

  div_result_t pending_results[$];
  div_row_t    directed_rows[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned zero_divisions = 0;

  always #1 clk = ~clk;

  divide_u64_by_u32_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // restoring division, one quotient bit per pass from the top dividend bit down;
  // the partial remainder stays below twice the divisor so 33 bits suffice
  function automatic div_result_t predict_division(input logic [DividendW-1:0] num,
                                                   input logic [DivisorW-1:0] den);
    div_result_t res;
    logic [DivisorW:0] partial;
    partial = '0;
    res = '0;
    if (den == '0) begin
      res.quot = '1;
      res.by_zero = 1'b1;
      return res;
    end
    for (int i = DividendW - 1; i >= 0; i--) begin
      partial = {partial[DivisorW-1:0], num[i]};
      if (partial >= {1'b0, den}) begin
        partial = partial - {1'b0, den};
        res.quot[i] = 1'b1;
      end
    end
    res.rem = partial[DivisorW-1:0];
    return res;
  endfunction

  function automatic void add_row(input logic [DividendW-1:0] num,
                                  input logic [DivisorW-1:0] den, input bit typed,
                                  input logic [DividendW-1:0] quot,
                                  input logic [DivisorW-1:0] rem, input logic by_zero);
    div_row_t row;
    row.num = num;
    row.den = den;
    row.typed = typed;
    row.want = '{quot: quot, rem: rem, by_zero: by_zero};
    directed_rows.push_back(row);
  endfunction

  // offers one division, with random idle cycles in front, and records the
  // expected result once the input transaction completes
  task automatic offer_division(input logic [DividendW-1:0] num,
                                input logic [DivisorW-1:0] den, input bit typed,
                                input div_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {den, num};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(typed ? want : predict_division(num, den));
  endtask

  // random operands, weighted towards the awkward corners of the division
  task automatic offer_random_division();
    logic [DividendW-1:0] num;
    logic [DivisorW-1:0]  den;
    int unsigned          kind;
    kind = $urandom_range(99);
    num = {$urandom, $urandom};
    den = $urandom;
    if (kind < 4) begin
      den = '0;                                   // divide-by-zero
    end else if (kind < 14) begin
      den = $urandom_range(255, 1);               // long quotients
    end else if (kind < 24) begin
      den = $urandom_range(32'hFFFF_FFFF, 1);     // divisor above the dividend
      num = {32'h0, 32'($urandom_range(den - 1, 0))};
    end else if (kind < 32) begin
      den = 32'h8000_0000 | $urandom;             // top divisor bit set
      num[63:32] = den - $urandom_range(1, 0);    // upper word at or just below divisor
    end else if (kind < 40) begin
      num = {32'h0, $urandom};                    // short dividends
    end else if (kind < 44) begin
      den = 32'h1 << $urandom_range(31, 0);       // powers of two
    end
    offer_division(num, den, 1'b0, '0);
  endtask

  // drop valid and let every outstanding result come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result sink: random back-pressure, plus a long hold-off when the stimulus
  // flips hold_toggle, counted here so the sender keeps offering meanwhile
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HoldCycles;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker: every output transaction against the oldest expectation
  always @(posedge clk) begin
    div_result_t want;
    div_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{quot: m_tdata[63:0], rem: m_tdata[95:64], by_zero: m_tuser};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got q=%h r=%h z=%b",
                 $time, got.quot, got.rem, got.by_zero);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.by_zero) zero_divisions++;
        if (got.quot !== want.quot) begin
          $display("%0t: quotient mismatch, expected %h, got %h", $time, want.quot, got.quot);
          error_count++;
        end
        if (got.rem !== want.rem) begin
          $display("%0t: remainder mismatch, expected %h, got %h", $time, want.rem, got.rem);
          error_count++;
        end
        if (got.by_zero !== want.by_zero) begin
          $display("%0t: divide_by_zero mismatch, expected %b, got %b",
                   $time, want.by_zero, got.by_zero);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // directed corners: zero divisor, extremes of both operands, divisor above
    // the dividend, and a few exact and inexact quotients
    add_row(64'h0, 32'h0, 1'b1, '1, '0, 1'b1);
    add_row('1, 32'h0, 1'b1, '1, '0, 1'b1);
    add_row(64'h1, 32'h0, 1'b1, '1, '0, 1'b1);
    add_row(64'h0, 32'h1, 1'b1, '0, '0, 1'b0);
    add_row('1, 32'h1, 1'b1, '1, '0, 1'b0);
    add_row('1, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0);
    add_row(64'h0, 32'hFFFF_FFFF, 1'b1, '0, '0, 1'b0);
    add_row(64'd5, 32'd7, 1'b1, '0, 32'd5, 1'b0);
    add_row(64'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, '0, 32'hFFFF_FFFE, 1'b0);
    add_row(64'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'd1, '0, 1'b0);
    add_row(64'h1_0000_0000, 32'hFFFF_FFFF, 1'b1, 64'd1, 32'd1, 1'b0);
    add_row(64'h8000_0000_0000_0000, 32'd2, 1'b1, 64'h4000_0000_0000_0000, '0, 1'b0);
    add_row('1, 32'd2, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 32'd1, 1'b0);
    add_row(64'd100, 32'd7, 1'b1, 64'd14, 32'd2, 1'b0);
    add_row(64'h1_0000_0000, 32'h8000_0000, 1'b1, 64'd2, '0, 1'b0);
    add_row(64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0);
    add_row(64'h0123_4567_89AB_CDEF, 32'h0000_1234, 1'b0, '0, '0, 1'b0);
    add_row(64'hDEAD_BEEF_CAFE_F00D, 32'h8000_0001, 1'b0, '0, '0, 1'b0);
    add_row(64'h7FFF_FFFF_FFFF_FFFF, 32'd3, 1'b0, '0, '0, 1'b0);
    add_row(64'hAAAA_AAAA_5555_5555, 32'h5555_5555, 1'b0, '0, '0, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // first mix: sender mostly busy, receiver mostly stalling
    send_idle_pct = 11;
    recv_idle_pct <= 88;
    foreach (directed_rows[i])
      offer_division(directed_rows[i].num, directed_rows[i].den,
                     directed_rows[i].typed, directed_rows[i].want);
    hold_toggle <= ~hold_toggle;  // long output stall while inputs keep coming
    for (int i = 0; i < RandomPerMix; i++) offer_random_division();
    drain_results();

    // second mix: sender mostly idle, receiver mostly ready
    send_idle_pct = 88;
    recv_idle_pct <= 11;
    hold_toggle <= ~hold_toggle;
    for (int i = 0; i < RandomPerMix; i++) offer_random_division();
    drain_results();

    // third mix: back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    for (int i = 0; i < RandomPerMix; i++) offer_random_division();
    drain_results();

    // catch any stray result after the last expected one
    repeat (TailCycles) @(posedge clk);

    $display("%0d divisions checked (%0d by zero), directed corners then random operands",
             results_checked, zero_divisions);
    $display("over three idle mixes, with a long result stall and full drains between mixes");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
